/* src/ssid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ssid_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_DUPLICATE  = 3'd1;
  localparam logic [2:0] ST_DELETED    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_READ_RANGE = 3'd5;

  localparam int READ_SLOTS = 16;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic [3:0]         position;
  } ssid_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         count;
    logic signed [31:0] read_value;
  } ssid_rsp_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic               compare;
    logic               insert;
    logic               remove;
    logic signed [31:0] value;
  } ssid_cell_ctl_t;

endpackage

`default_nettype wire

/* src/ssid_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted chain. It compares its entry against the broadcast
// value, then either keeps its entry or takes the new value or a neighbor's.
module ssid_cell (
  input  wire logic                    clk,
  input  wire ssid_pkg::ssid_cell_ctl_t ctl,
  input  wire logic                    occ,
  input  wire logic signed [31:0]      left_entry,
  input  wire logic                    left_lt,
  input  wire logic signed [31:0]      right_entry,
  output logic signed [31:0]           entry,
  output logic                         lt,
  output logic                         eq
);

  always_ff @(posedge clk) begin
    if (ctl.compare) begin
      lt <= occ && (entry < ctl.value);
      eq <= occ && (entry == ctl.value);
    end
    if (ctl.insert) begin
      // Slots at or above the insert point move up by one place.
      if (!lt) begin
        entry <= left_lt ? ctl.value : left_entry;
      end
    end else if (ctl.remove) begin
      // Slots at or above the match move down by one place.
      if (!lt) begin
        entry <= right_entry;
      end
    end
  end

endmodule

`default_nettype wire

/* src/sorted_set_insert_delete_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// A transaction is accepted when start is high while idle; the request is
// registered, the cell chain updates in the execute state, and the result is
// registered on rsp and strobed on done. Busy is high for the single cycle in
// which the cell chain updates, blocking new starts. Results cannot be stalled.
// Reset (rst, synchronous, active high) empties the set; entry contents are
// not cleared and are never visible until written.
module sorted_set_insert_delete_unit #(
  parameter int CAPACITY = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire ssid_pkg::ssid_req_t req,
  output logic                     done,
  output ssid_pkg::ssid_rsp_t      rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                      state;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  ssid_pkg::ssid_req_t       req_q;
  ssid_pkg::ssid_cell_ctl_t  ctl;
  ssid_pkg::ssid_rsp_t       rsp_next;

  logic signed [31:0] entries [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic signed [31:0]  rd_tab [ssid_pkg::READ_SLOTS];

  logic accept;
  logic found;
  logic full;
  logic pos_ok;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state == ST_EXEC);

  // Since the entries are sorted and distinct, at most one cell matches.
  assign found = |eq_vec;
  assign full  = (count == CW'(CAPACITY));

  // The compare happens in the accept cycle against the incoming value; the
  // shift happens in the execute cycle against the latched request.
  always_comb begin
    ctl.compare = accept;
    ctl.insert  = busy && (req_q.cmd == ssid_pkg::CMD_INSERT) && !found && !full;
    ctl.remove  = busy && (req_q.cmd == ssid_pkg::CMD_DELETE) && found;
    ctl.value   = accept ? req.value : req_q.value;
  end

  // The chain: each cell sees its neighbors' entries and its left neighbor's
  // less-than flag, which together locate the insert point without any
  // global search.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_e;
    logic               left_l;
    logic signed [31:0] right_e;

    if (i == 0) begin : g_first
      assign left_e = ctl.value;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign left_l = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    ssid_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (CW'(i) < count),
      .left_entry  (left_e),
      .left_lt     (left_l),
      .right_entry (right_e),
      .entry       (entries[i]),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  // Read port: the position field reaches only the first sixteen slots.
  for (genvar j = 0; j < ssid_pkg::READ_SLOTS; j++) begin : g_rd
    if (j < CAPACITY) begin : g_used
      assign rd_tab[j] = entries[j];
    end else begin : g_none
      assign rd_tab[j] = '0;
    end
  end

  assign pos_ok = (32'(req_q.position) < CAPACITY) &&
                  (32'(req_q.position) < 32'(count));

  // Result of the transaction in the execute cycle.
  always_comb begin
    count_next          = count;
    rsp_next.read_value = '0;
    rsp_next.status     = ssid_pkg::ST_OK;
    unique case (req_q.cmd)
      ssid_pkg::CMD_INSERT: begin
        if (found) begin
          rsp_next.status = ssid_pkg::ST_DUPLICATE;
        end else if (full) begin
          rsp_next.status = ssid_pkg::ST_FULL;
        end else begin
          rsp_next.status = ssid_pkg::ST_OK;
          count_next      = count + 1'b1;
        end
      end
      ssid_pkg::CMD_DELETE: begin
        if (found) begin
          rsp_next.status = ssid_pkg::ST_DELETED;
          count_next      = count - 1'b1;
        end else begin
          rsp_next.status = ssid_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        // Read, including the unused fourth command code.
        if (pos_ok) begin
          rsp_next.status     = ssid_pkg::ST_OK;
          rsp_next.read_value = rd_tab[req_q.position];
        end else begin
          rsp_next.status = ssid_pkg::ST_READ_RANGE;
        end
      end
    endcase
    // The reported count is the count after this transaction, taken to five bits.
    rsp_next.count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          count <= count_next;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

/* src/ssid_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssid_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire ssid_pkg::ssid_rsp_t rsp
);

  // Every accepted transaction goes through its execute state and then yields its result on done.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction produced no result");

  // A result only appears after an execute cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // The execute phase lasts one cycle.
  a_busy_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // Only a successful read carries data; every other status reads zero.
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != ssid_pkg::ST_OK)) |-> (rsp.read_value == 32'sd0))
    else $error("nonzero read data on a non-read status");

  // The status code stays within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status <= ssid_pkg::ST_READ_RANGE))
    else $error("status code out of range");

endmodule

bind sorted_set_insert_delete_unit ssid_checker u_ssid_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire
